/* design/ttf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the triangle tangent frame block
// no dependencies

package ttf_pkg;

    localparam int COORD_BITS = 16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [COORD_BITS-1:0] tex_u;
        logic signed [COORD_BITS-1:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic signed [15:0] unit_normal_x;
        logic signed [15:0] unit_normal_y;
        logic signed [15:0] unit_normal_z;
        logic               uv_degenerate;
        logic               area_degenerate;
    } t_result;

    // aligned Q3.12 coordinate held for the first two vertices
    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] tu;
        logic signed [15:0] tv;
    } t_aligned;

    localparam int NUM_PAIRS    = 10;
    localparam int TB_QBITS     = 33;
    localparam int NRM_QBITS    = 16;
    localparam int SQRT_STEPS   = 32;

endpackage

/* design/triangle_tangent_frame.sv */
`timescale 1ns / 1ps
// triangle tangent frame: tangent, bitangent and unit normal per triangle
// depends on ttf_pkg
//
// usage: vertices arrive one request at a time on i_vertex, qualified by
// i_start and accepted while o_busy is low. the first two vertices of a
// triangle are stored and accepted back to back with no wait. the third
// vertex starts the computation and holds o_busy high until the result
// has been shown. the result appears on o_result for exactly one cycle
// with o_valid high; the receiver cannot stall it.
// all arithmetic runs through one 33x33 multiplier and one restoring
// divide/compare-subtract unit under a small sequencer: 20 products,
// six 33-step tangent divides, up to 30 one-bit normalizing shifts,
// three squares, a 32-step square root and three 16-step normal divides.
// the number of normalizing shifts sets how long the computation runs; when the
// cross product is zero the shifts, squares, square root and normal divides are skipped.
// reset clears the vertex phase and the sequencer; no result is pending.

module triangle_tangent_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ttf_pkg::t_vertex  i_vertex,
    output logic              o_busy,
    output logic              o_valid,
    output ttf_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DLOAD, S_DSTEP, S_DFIN,
        S_NABS, S_NSHIFT, S_NSQ, S_SQRT, S_OUT
    } t_state;

    function automatic logic signed [15:0] f_align(
        input logic signed [ttf_pkg::COORD_BITS-1:0] v);
        logic signed [47:0] t;
        begin
            t = {{(48-ttf_pkg::COORD_BITS){v[ttf_pkg::COORD_BITS-1]}}, v};
            if (ttf_pkg::COORD_BITS >= 16) begin
                t = t >>> ((ttf_pkg::COORD_BITS >= 16) ? ttf_pkg::COORD_BITS - 16 : 0);
            end else begin
                t = t <<< ((ttf_pkg::COORD_BITS < 16) ? 16 - ttf_pkg::COORD_BITS : 0);
            end
            return t[15:0];
        end
    endfunction

    function automatic logic [35:0] f_mag(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    t_state              r_state;
    logic [1:0]          r_phase;
    ttf_pkg::t_aligned   r_hold [2];
    logic signed [16:0]  r_e0 [3];
    logic signed [16:0]  r_e1 [3];
    logic signed [16:0]  r_du0, r_dv0, r_du1, r_dv1;
    logic signed [35:0]  r_acc;
    logic signed [35:0]  r_val [ttf_pkg::NUM_PAIRS];
    logic [5:0]          r_cnt;
    logic [2:0]          r_idx;
    logic                r_nmode;
    logic [37:0]         r_rem;
    logic [32:0]         r_lo;
    logic [37:0]         r_dsr;
    logic [32:0]         r_q;
    logic                r_ovf;
    logic                r_neg;
    logic                r_uvdeg;
    logic                r_areadeg;
    logic [35:0]         r_m [3];
    logic [63:0]         r_x;
    logic [63:0]         r_res;
    logic [63:0]         r_bit;
    logic [31:0]         r_tb [6];
    logic [15:0]         r_nrm [3];

    ttf_pkg::t_aligned   cur;
    logic                accept;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic [3:0]          pair;
    logic [3:0]          vidx;
    logic [35:0]         un, ud;
    logic [37:0]         n_rem_sh;
    logic                n_qbit;
    logic [64:0]         n_trial;
    logic                n_take;
    logic [63:0]         n_res;
    logic [33:0]         q_tb;
    logic [16:0]         q_nrm;
    logic [31:0]         tb_word;
    logic [15:0]         nrm_word;
    logic                big, b30;

    assign accept  = i_start && !o_busy;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        cur.px = f_align(i_vertex.pos_x);
        cur.py = f_align(i_vertex.pos_y);
        cur.pz = f_align(i_vertex.pos_z);
        cur.tu = f_align(i_vertex.tex_u);
        cur.tv = f_align(i_vertex.tex_v);
    end

    // shared multiplier operand select
    assign pair = r_cnt[4:1];
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_NSQ) begin
            mul_a = {2'b00, r_m[r_cnt[1:0]][30:0]};
            mul_b = {2'b00, r_m[r_cnt[1:0]][30:0]};
        end else begin
            case (pair)
                4'd0: begin
                    mul_a = 33'(r_cnt[0] ? r_du1 : r_du0);
                    mul_b = 33'(r_cnt[0] ? r_dv0 : r_dv1);
                end
                4'd1, 4'd2, 4'd3: begin
                    mul_a = 33'(r_cnt[0] ? r_dv0 : r_dv1);
                    mul_b = 33'(r_cnt[0] ? r_e1[2'(pair - 4'd1)] : r_e0[2'(pair - 4'd1)]);
                end
                4'd4, 4'd5, 4'd6: begin
                    mul_a = 33'(r_cnt[0] ? r_du1 : r_du0);
                    mul_b = 33'(r_cnt[0] ? r_e0[2'(pair - 4'd4)] : r_e1[2'(pair - 4'd4)]);
                end
                4'd7: begin
                    mul_a = 33'(r_cnt[0] ? r_e0[2] : r_e0[1]);
                    mul_b = 33'(r_cnt[0] ? r_e1[1] : r_e1[2]);
                end
                4'd8: begin
                    mul_a = 33'(r_cnt[0] ? r_e0[0] : r_e0[2]);
                    mul_b = 33'(r_cnt[0] ? r_e1[2] : r_e1[0]);
                end
                4'd9: begin
                    mul_a = 33'(r_cnt[0] ? r_e0[1] : r_e0[0]);
                    mul_b = 33'(r_cnt[0] ? r_e1[0] : r_e1[1]);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end
    assign prod = mul_a * mul_b;

    // divider and square root step
    assign vidx     = 4'(r_idx) + 4'd1;
    assign un       = f_mag(r_val[vidx]);
    assign ud       = f_mag(r_val[0]);
    assign n_rem_sh = {r_rem[36:0], r_lo[32]};
    assign n_qbit   = (n_rem_sh >= r_dsr);
    assign n_trial  = {1'b0, r_res} + {1'b0, r_bit};
    assign n_take   = ({1'b0, r_x} >= n_trial);
    assign n_res    = n_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // rounding of the finished quotient and saturation of the tangent words
    assign q_tb  = ({1'b0, r_q} + 34'd1) >> 1;
    assign q_nrm = ({1'b0, r_q[15:0]} + 17'd1) >> 1;
    always_comb begin
        if (r_uvdeg || q_tb == '0) begin
            tb_word = '0;
        end else if (r_neg) begin
            tb_word = (r_ovf || q_tb > 34'h080000000) ? 32'h80000000 : 32'(-q_tb);
        end else begin
            tb_word = (r_ovf || q_tb > 34'h07fffffff) ? 32'h7fffffff : q_tb[31:0];
        end
        nrm_word = r_val[4'd7 + 4'(r_idx)][35] ? 16'(-q_nrm) : q_nrm[15:0];
    end

    assign big = (|r_m[0][35:31]) || (|r_m[1][35:31]) || (|r_m[2][35:31]);
    assign b30 = r_m[0][30] || r_m[1][30] || r_m[2][30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_nmode   <= 1'b0;
            r_areadeg <= 1'b0;
            r_uvdeg   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_phase < 2'd2) begin
                            r_hold[r_phase[0]] <= cur;
                            r_phase <= r_phase + 2'd1;
                        end else begin
                            r_phase <= '0;
                            r_e0[0] <= 17'(r_hold[1].px) - 17'(r_hold[0].px);
                            r_e0[1] <= 17'(r_hold[1].py) - 17'(r_hold[0].py);
                            r_e0[2] <= 17'(r_hold[1].pz) - 17'(r_hold[0].pz);
                            r_e1[0] <= 17'(cur.px) - 17'(r_hold[0].px);
                            r_e1[1] <= 17'(cur.py) - 17'(r_hold[0].py);
                            r_e1[2] <= 17'(cur.pz) - 17'(r_hold[0].pz);
                            r_du0   <= 17'(r_hold[1].tu) - 17'(r_hold[0].tu);
                            r_dv0   <= 17'(r_hold[1].tv) - 17'(r_hold[0].tv);
                            r_du1   <= 17'(cur.tu) - 17'(r_hold[0].tu);
                            r_dv1   <= 17'(cur.tv) - 17'(r_hold[0].tv);
                            r_cnt   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_cnt[0]) begin
                        r_acc <= prod[35:0];
                    end else begin
                        r_val[pair] <= r_acc - prod[35:0];
                    end
                    if (r_cnt == 6'd19) begin
                        r_idx   <= '0;
                        r_nmode <= 1'b0;
                        r_state <= S_DLOAD;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DLOAD: begin
                    r_cnt <= '0;
                    r_q   <= '0;
                    if (!r_nmode) begin
                        r_rem   <= 38'(un >> 16);
                        r_lo    <= {un[15:0], 17'd0};
                        r_dsr   <= 38'(ud);
                        r_ovf   <= ({16'd0, un} >= {ud, 16'd0});
                        r_neg   <= r_val[vidx][35] ^ r_val[0][35];
                        r_uvdeg <= (r_val[0] == '0);
                    end else begin
                        r_rem <= 38'(r_m[r_idx[1:0]] >> 1);
                        r_lo  <= {r_m[r_idx[1:0]][0], 32'd0};
                        r_dsr <= r_res[37:0];
                    end
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    r_rem <= n_qbit ? (n_rem_sh - r_dsr) : n_rem_sh;
                    r_q   <= {r_q[31:0], n_qbit};
                    r_lo  <= {r_lo[31:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == (r_nmode ? 6'(ttf_pkg::NRM_QBITS - 1)
                                          : 6'(ttf_pkg::TB_QBITS - 1))) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (!r_nmode) begin
                        r_tb[r_idx] <= tb_word;
                        if (r_idx == 3'd5) begin
                            r_state <= S_NABS;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_DLOAD;
                        end
                    end else begin
                        r_nrm[r_idx[1:0]] <= nrm_word;
                        if (r_idx == 3'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_DLOAD;
                        end
                    end
                end
                S_NABS: begin
                    r_m[0] <= f_mag(r_val[7]);
                    r_m[1] <= f_mag(r_val[8]);
                    r_m[2] <= f_mag(r_val[9]);
                    if (r_val[7] == '0 && r_val[8] == '0 && r_val[9] == '0) begin
                        r_areadeg <= 1'b1;
                        r_nrm[0]  <= '0;
                        r_nrm[1]  <= '0;
                        r_nrm[2]  <= '0;
                        r_state   <= S_OUT;
                    end else begin
                        r_areadeg <= 1'b0;
                        r_state   <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    if (big) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else if (!b30) begin
                        r_m[0] <= r_m[0] << 1;
                        r_m[1] <= r_m[1] << 1;
                        r_m[2] <= r_m[2] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_x     <= '0;
                        r_state <= S_NSQ;
                    end
                end
                S_NSQ: begin
                    r_x <= r_x + prod[63:0];
                    if (r_cnt == 6'd2) begin
                        r_cnt   <= '0;
                        r_res   <= '0;
                        r_bit   <= 64'h4000000000000000;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    if (n_take) begin
                        r_x <= r_x - n_trial[63:0];
                    end
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(ttf_pkg::SQRT_STEPS - 1)) begin
                        r_idx   <= '0;
                        r_nmode <= 1'b1;
                        r_state <= S_DLOAD;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.tangent_x       = r_tb[0];
        o_result.tangent_y       = r_tb[1];
        o_result.tangent_z       = r_tb[2];
        o_result.bitangent_x     = r_tb[3];
        o_result.bitangent_y     = r_tb[4];
        o_result.bitangent_z     = r_tb[5];
        o_result.unit_normal_x   = r_nrm[0];
        o_result.unit_normal_y   = r_nrm[1];
        o_result.unit_normal_z   = r_nrm[2];
        o_result.uv_degenerate   = r_uvdeg;
        o_result.area_degenerate = r_areadeg;
    end

endmodule

/* dv/tb_triangle_tangent_frame.sv */
`timescale 1ns / 1ps
// testbench for triangle_tangent_frame: drives vertex requests and checks every frame
// against a bit-accurate predictor held in a small scoreboard class
// depends on ttf_pkg and the triangle_tangent_frame rtl

module tb_triangle_tangent_frame;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_VERTS   = 926;

    class frame_scoreboard;
        ttf_pkg::t_result  pending[$];
        ttf_pkg::t_aligned held[2];
        int       phase;
        int       errors;
        int       frames;
        int       uv_flat;
        int       area_flat;

        function new();
            phase = 0;
            errors = 0;
            frames = 0;
            uv_flat = 0;
            area_flat = 0;
        endfunction

        function automatic logic signed [31:0] tb_div(longint num, longint den);
            longint un, ud, q;
            bit     neg;
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            neg = (num < 0) != (den < 0);
            q = (2 * un * 65536 + ud) / (2 * ud);
            if (q == 0) return 0;
            if (neg) return (q > 64'sd2147483648) ? 32'sh8000_0000 : 32'(-q);
            return (q > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(q);
        endfunction

        function automatic longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_vertex(ttf_pkg::t_vertex v);
            ttf_pkg::t_aligned cur;
            ttf_pkg::t_result  r;
            longint   e0[3], e1[3], c[3], p0[3], p1[3], pc[3];
            longint   du0, dv0, du1, dv1, det;
            longint unsigned m[3], mx, sum, rt, q;
            cur = '{v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v};
            if (phase < 2) begin
                held[phase] = cur;
                phase++;
                return;
            end
            phase = 0;
            p0 = '{held[0].px, held[0].py, held[0].pz};
            p1 = '{held[1].px, held[1].py, held[1].pz};
            pc = '{cur.px, cur.py, cur.pz};
            for (int i = 0; i < 3; i++) begin
                e0[i] = p1[i] - p0[i];
                e1[i] = pc[i] - p0[i];
            end
            du0 = longint'(held[1].tu) - held[0].tu;
            dv0 = longint'(held[1].tv) - held[0].tv;
            du1 = longint'(cur.tu) - held[0].tu;
            dv1 = longint'(cur.tv) - held[0].tv;
            det = du0 * dv1 - du1 * dv0;
            r = '0;
            if (det != 0) begin
                r.tangent_x   = tb_div(dv1 * e0[0] - dv0 * e1[0], det);
                r.tangent_y   = tb_div(dv1 * e0[1] - dv0 * e1[1], det);
                r.tangent_z   = tb_div(dv1 * e0[2] - dv0 * e1[2], det);
                r.bitangent_x = tb_div(du0 * e1[0] - du1 * e0[0], det);
                r.bitangent_y = tb_div(du0 * e1[1] - du1 * e0[1], det);
                r.bitangent_z = tb_div(du0 * e1[2] - du1 * e0[2], det);
            end else begin
                r.uv_degenerate = 1'b1;
                uv_flat++;
            end
            c[0] = e0[1] * e1[2] - e0[2] * e1[1];
            c[1] = e0[2] * e1[0] - e0[0] * e1[2];
            c[2] = e0[0] * e1[1] - e0[1] * e1[0];
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (c[i] < 0) ? -c[i] : c[i];
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0) begin
                r.area_degenerate = 1'b1;
                area_flat++;
            end else begin
                while (mx >= (64'd1 << 31)) begin
                    mx >>= 1;
                    for (int i = 0; i < 3; i++) m[i] >>= 1;
                end
                while (mx < (64'd1 << 30)) begin
                    mx <<= 1;
                    for (int i = 0; i < 3; i++) m[i] <<= 1;
                end
                sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                rt = floor_sqrt(sum);
                for (int i = 0; i < 3; i++) begin
                    q = (2 * m[i] * 16384 + rt) / (2 * rt);
                    if (c[i] < 0) q = -q;
                    case (i)
                        0: r.unit_normal_x = q[15:0];
                        1: r.unit_normal_y = q[15:0];
                        default: r.unit_normal_z = q[15:0];
                    endcase
                end
            end
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch frame %0d %s: got %0h want %0h", frames, what, got, want);
            errors++;
        endtask

        task check_frame(ttf_pkg::t_result got);
            ttf_pkg::t_result w;
            if (pending.size() == 0) begin
                report("unexpected frame", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.tangent_x !== w.tangent_x) report("tangent_x", got.tangent_x, w.tangent_x);
            if (got.tangent_y !== w.tangent_y) report("tangent_y", got.tangent_y, w.tangent_y);
            if (got.tangent_z !== w.tangent_z) report("tangent_z", got.tangent_z, w.tangent_z);
            if (got.bitangent_x !== w.bitangent_x)
                report("bitangent_x", got.bitangent_x, w.bitangent_x);
            if (got.bitangent_y !== w.bitangent_y)
                report("bitangent_y", got.bitangent_y, w.bitangent_y);
            if (got.bitangent_z !== w.bitangent_z)
                report("bitangent_z", got.bitangent_z, w.bitangent_z);
            if (got.unit_normal_x !== w.unit_normal_x)
                report("unit_normal_x", got.unit_normal_x, w.unit_normal_x);
            if (got.unit_normal_y !== w.unit_normal_y)
                report("unit_normal_y", got.unit_normal_y, w.unit_normal_y);
            if (got.unit_normal_z !== w.unit_normal_z)
                report("unit_normal_z", got.unit_normal_z, w.unit_normal_z);
            if (got.uv_degenerate !== w.uv_degenerate)
                report("uv_degenerate", got.uv_degenerate, w.uv_degenerate);
            if (got.area_degenerate !== w.area_degenerate)
                report("area_degenerate", got.area_degenerate, w.area_degenerate);
            frames++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    ttf_pkg::t_vertex  i_vertex;
    logic              o_busy;
    logic              o_valid;
    ttf_pkg::t_result  o_result;

    frame_scoreboard sb;
    int  idle_cycles;
    int  burst_left;
    int  verts_sent;
    bit  timed_out;

    triangle_tangent_frame dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_vertex (i_vertex),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_frame(o_result);
            if (o_valid || (i_start && !o_busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // one vertex request: held until taken, then a random gap between bursts
    task send_vertex(ttf_pkg::t_vertex v);
        i_vertex = v;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_vertex(v);
        verts_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_start = 1'b0;
            i_vertex = ttf_pkg::t_vertex'(80'({$urandom, $urandom, $urandom}));
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 9);
        end
    endtask

    function automatic logic [15:0] rnd_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 8191)) - 16'd4096;
        endcase
    endfunction

    task send_triangle(ttf_pkg::t_vertex a, ttf_pkg::t_vertex b, ttf_pkg::t_vertex c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    function automatic ttf_pkg::t_vertex rnd_vertex();
        int mode;
        mode = ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 1) ? 0 : 2);
        return '{rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                 rnd_coord(mode), rnd_coord(mode)};
    endfunction

    initial begin
        ttf_pkg::t_vertex a, b, c;
        sb = new();
        idle_cycles = 0;
        burst_left = 0;
        verts_sent = 0;
        timed_out = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_vertex = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ordinary, flat uv, collinear, coincident, extremes
        send_triangle('{0, 0, 0, 0, 0}, '{4096, 0, 0, 4096, 0}, '{0, 4096, 0, 0, 4096});
        send_triangle('{0, 0, 0, 5, 5}, '{4096, 0, 0, 5, 5}, '{0, 4096, 0, 5, 5});
        send_triangle('{0, 0, 0, 0, 0}, '{100, 200, 300, 1, 0}, '{200, 400, 600, 0, 1});
        send_triangle('{7, 7, 7, 0, 0}, '{7, 7, 7, 0, 0}, '{7, 7, 7, 0, 0});
        send_triangle('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
                      '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8001},
                      '{16'h8000, 16'h7fff, 16'h7fff, 16'h8001, 16'h8000});
        // tiny uv det with huge edges drives saturation
        send_triangle('{16'h8000, 16'h8000, 16'h8000, 0, 0},
                      '{16'h7fff, 16'h8000, 16'h7fff, 1, 0},
                      '{16'h8000, 16'h7fff, 16'h7fff, 0, 1});
        send_triangle('{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000},
                      '{16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff},
                      '{16'hffff, 16'h0000, 16'hffff, 16'h7fff, 16'h7fff});
        send_triangle('{-1, 0, 0, -1, 0}, '{0, -1, 0, 0, -1}, '{0, 0, -1, 1, 1});

        while (verts_sent < 24 + RANDOM_VERTS) begin
            a = rnd_vertex();
            b = rnd_vertex();
            c = rnd_vertex();
            case ($urandom_range(0, 9))
                0: b = a;
                1: c = '{b.pos_x, b.pos_y, b.pos_z, c.tex_u, c.tex_v};
                2: c = '{c.pos_x, c.pos_y, c.pos_z, b.tex_u, b.tex_v};
                3: begin
                    b.tex_u = a.tex_u;
                    c.tex_u = a.tex_u;
                end
                default: ;
            endcase
            send_triangle(a, b, c);
        end
        i_start = 1'b0;

        while (sb.pending.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d vertices sent, %0d frames checked (%0d flat uv, %0d zero area)",
                 verts_sent, sb.frames, sb.uv_flat, sb.area_flat);
        if (sb.errors == 0 && sb.pending.size() == 0 && !timed_out) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
